>>> rtl/fat_pkg.sv
// Shared types and constants for the allocation table chain resize and locate block.
// Used by fat_div, the top level and the checker; depends on nothing.
package fat_pkg;

  localparam int SIZE_W = 24;
  localparam int BS_W = 17;
  localparam int BLK_W = 10;
  localparam int STAT_W = 2;
  localparam int CFG_IDX_W = 1;
  localparam int DIV_STEPS = SIZE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [BS_W-1:0] BS_RESET = 17'd512;
  localparam logic [BLK_W-1:0] FIRST_RESET = 10'd1;

  localparam logic [STAT_W-1:0] ST_OK = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_SHORT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BLOCK = 1'b1;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV_OLD,
    S_DIV_NEW,
    S_DIV_HOP,
    S_DECIDE,
    S_LOC_RD,
    S_LOC_USE,
    S_TAIL_RD,
    S_TAIL_USE,
    S_CNT_RD,
    S_CNT_USE,
    S_FIND_RD,
    S_FIND_USE,
    S_LINK_WR,
    S_END_WR,
    S_FREE_RD,
    S_FREE_USE,
    S_KEEP_RD,
    S_KEEP_USE,
    S_CUT_RD,
    S_CUT_USE,
    S_DONE
  } fat_state_e;

endpackage

>>> rtl/fat_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module fat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/fat_div.sv
// Restoring divider, one quotient bit per cycle, for block counts and hop counts.
// Depends on fat_pkg.
module fat_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [fat_pkg::SIZE_W-1:0] dividend_i,
  input  logic [fat_pkg::BS_W-1:0]   divisor_i,
  output logic                      done_o,
  output logic [fat_pkg::SIZE_W-1:0] quot_o,
  output logic                      rem_nz_o
);
  import fat_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [BS_W-1:0]      rem_q;
  logic [SIZE_W-1:0]    quo_q;
  logic [BS_W:0]        trial;
  logic [BS_W:0]        diff;
  logic                 take;

  always_comb begin
    trial = {rem_q, quo_q[SIZE_W-1]};
    diff = trial - {1'b0, divisor_i};
    take = trial >= {1'b0, divisor_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= DIV_CNT_W'(DIV_STEPS);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= take ? diff[BS_W-1:0] : trial[BS_W-1:0];
      quo_q <= {quo_q[SIZE_W-2:0], take};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_nz_o = |rem_q;

endmodule

>>> rtl/fat_chain_resize_and_locate.sv
// Top level: allocation table sequencer for chain resize and byte offset locate.
// Depends on fat_pkg, fat_ram and fat_div.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_stall_o    cmd, start_block, current_size, target
//   out      output     out_valid_o / out_stall_i  status, new_start_block, found_block
//   cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// After reset the table is cleared one entry a cycle, all TABLE_ENTRIES of them, with in_stall_o high.
// A locate beat runs one division for the hop count and then reads one link per hop; a resize runs
// two block count divisions and then walks links or frees entries.
// Growth also scans the table twice, a read state and a use state per entry, once to count free
// entries and once to take them.
// The table has a single read port, and one divider is shared by all the divisions.
// A finished result waits in the output register while out_stall_i is high.
module fat_chain_resize_and_locate #(
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          cmd_i,
  input  logic [fat_pkg::BLK_W-1:0]     start_block_i,
  input  logic [fat_pkg::SIZE_W-1:0]    current_size_i,
  input  logic [fat_pkg::SIZE_W-1:0]    target_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [fat_pkg::STAT_W-1:0]    status_o,
  output logic [fat_pkg::BLK_W-1:0]     new_start_block_o,
  output logic [fat_pkg::BLK_W-1:0]     found_block_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fat_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [fat_pkg::BS_W-1:0]      cfg_data_i
);
  import fat_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int EW = AW + 1;
  localparam int PW = (AW > BLK_W ? AW : BLK_W) + 1;
  localparam logic [EW-1:0] END_MARK = '1;

  function automatic logic is_link(input logic [EW-1:0] v);
    return (v != '0) && (32'(v) < TABLE_ENTRIES);
  endfunction

  fat_state_e state_q, state_d;
  logic [BS_W-1:0]   bs_q;
  logic [BLK_W-1:0]  first_q;
  logic [PW-1:0]     ptr_q, ptr_d;
  logic              out_valid_q, out_valid_d;
  logic [STAT_W-1:0] out_status_q, out_status_d;
  logic [BLK_W-1:0]  out_start_q, out_start_d;
  logic [BLK_W-1:0]  out_found_q, out_found_d;

  logic [AW-1:0]     start_q, start_d;
  logic [AW-1:0]     cur_q, cur_d;
  logic [AW-1:0]     nb_q, nb_d;
  logic [SIZE_W-1:0] tgt_q, tgt_d;
  logic [SIZE_W-1:0] cnt_q, cnt_d;
  logic [SIZE_W-1:0] oldn_q, oldn_d;
  logic [SIZE_W-1:0] newn_q, newn_d;
  logic [PW-1:0]     avail_q, avail_d;
  logic [PW-1:0]     steps_q, steps_d;
  logic              has_tail_q, has_tail_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic [BLK_W-1:0]  res_q, res_d;
  logic [AW-1:0]     found_q, found_d;

  logic [BS_W-1:0]   bs_eff;
  logic [PW-1:0]     first_eff;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [EW-1:0]     ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [EW-1:0]     rd;
  logic              div_start;
  logic [SIZE_W-1:0] div_dividend;
  logic              div_done;
  logic [SIZE_W-1:0] div_quot;
  logic              div_rem_nz;
  logic [SIZE_W-1:0] ceil_q;
  logic              scan_end;
  logic              grow_ok;

  assign bs_eff = (bs_q == '0) ? BS_W'(1) : bs_q;
  assign first_eff = (first_q == '0) ? PW'(1) : PW'(first_q);
  assign ceil_q = div_quot + SIZE_W'(div_rem_nz);
  assign scan_end = ptr_q >= PW'(TABLE_ENTRIES);
  assign grow_ok = SIZE_W'(avail_q) >= cnt_q;

  fat_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(rd)
  );

  fat_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (bs_eff),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_nz_o  (div_rem_nz)
  );

  always_comb begin
    state_d = state_q;
    ptr_d = ptr_q;
    out_valid_d = out_valid_q;
    out_status_d = out_status_q;
    out_start_d = out_start_q;
    out_found_d = out_found_q;
    start_d = start_q;
    cur_d = cur_q;
    nb_d = nb_q;
    tgt_d = tgt_q;
    cnt_d = cnt_q;
    oldn_d = oldn_q;
    newn_d = newn_q;
    avail_d = avail_q;
    steps_d = steps_q;
    has_tail_d = has_tail_q;
    status_d = status_q;
    res_d = res_q;
    found_d = found_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_CLEAR: begin
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == PW'(TABLE_ENTRIES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          start_d = (32'(start_block_i) >= TABLE_ENTRIES) ? '0 : AW'(start_block_i);
          tgt_d = target_i;
          status_d = ST_OK;
          found_d = '0;
          res_d = start_block_i;
          state_d = cmd_i ? S_DIV_HOP : S_DIV_OLD;
        end
      end
      S_DIV_OLD: begin
        if (div_done) begin
          oldn_d = ceil_q;
          state_d = S_DIV_NEW;
        end
      end
      S_DIV_NEW: begin
        if (div_done) begin
          newn_d = ceil_q;
          state_d = S_DECIDE;
        end
      end
      S_DIV_HOP: begin
        if (div_done) begin
          cnt_d = div_quot;
          cur_d = start_q;
          if (start_q == '0 || 32'(div_quot) >= TABLE_ENTRIES) begin
            status_d = ST_SHORT;
            state_d = S_DONE;
          end else begin
            state_d = S_LOC_RD;
          end
        end
      end
      S_DECIDE: begin
        res_d = BLK_W'(start_q);
        cur_d = start_q;
        if (newn_q > oldn_q) begin
          cnt_d = newn_q - oldn_q;
          has_tail_d = start_q != '0;
          steps_d = '0;
          ptr_d = first_eff;
          avail_d = '0;
          state_d = (start_q != '0) ? S_TAIL_RD : S_CNT_RD;
        end else if (newn_q < oldn_q) begin
          if (start_q == '0) begin
            state_d = S_DONE;
          end else if (newn_q == '0) begin
            cnt_d = oldn_q;
            res_d = '0;
            state_d = S_FREE_RD;
          end else if (32'(newn_q - SIZE_W'(1)) >= TABLE_ENTRIES) begin
            state_d = S_DONE;
          end else begin
            cnt_d = newn_q - SIZE_W'(1);
            state_d = S_KEEP_RD;
          end
        end else begin
          state_d = S_DONE;
        end
      end
      S_LOC_RD: begin
        if (cnt_q == '0) begin
          found_d = cur_q;
          state_d = S_DONE;
        end else begin
          state_d = S_LOC_USE;
        end
      end
      S_LOC_USE: begin
        if (!is_link(rd)) begin
          status_d = ST_SHORT;
          state_d = S_DONE;
        end else begin
          cur_d = AW'(rd);
          cnt_d = cnt_q - 1'b1;
          state_d = S_LOC_RD;
        end
      end
      S_TAIL_RD: begin
        state_d = (steps_q == PW'(TABLE_ENTRIES)) ? S_CNT_RD : S_TAIL_USE;
      end
      S_TAIL_USE: begin
        if (!is_link(rd)) begin
          state_d = S_CNT_RD;
        end else begin
          cur_d = AW'(rd);
          steps_d = steps_q + 1'b1;
          state_d = S_TAIL_RD;
        end
      end
      S_CNT_RD: begin
        if (scan_end) begin
          if (!grow_ok) begin
            status_d = ST_FULL;
            state_d = S_DONE;
          end else begin
            ptr_d = first_eff;
            state_d = S_FIND_RD;
          end
        end else begin
          state_d = S_CNT_USE;
        end
      end
      S_CNT_USE: begin
        if (rd == '0 && !(has_tail_q && ptr_q[AW-1:0] == cur_q)) begin
          avail_d = avail_q + 1'b1;
        end
        ptr_d = ptr_q + 1'b1;
        state_d = S_CNT_RD;
      end
      S_FIND_RD: begin
        state_d = scan_end ? S_DONE : S_FIND_USE;
      end
      S_FIND_USE: begin
        if (rd == '0) begin
          nb_d = ptr_q[AW-1:0];
          state_d = S_LINK_WR;
        end else begin
          ptr_d = ptr_q + 1'b1;
          state_d = S_FIND_RD;
        end
      end
      S_LINK_WR: begin
        if (!has_tail_q) begin
          res_d = BLK_W'(nb_q);
          has_tail_d = 1'b1;
        end
        state_d = S_END_WR;
      end
      S_END_WR: begin
        cur_d = nb_q;
        cnt_d = cnt_q - 1'b1;
        ptr_d = PW'(nb_q) + 1'b1;
        state_d = (cnt_q == SIZE_W'(1)) ? S_DONE : S_FIND_RD;
      end
      S_FREE_RD: begin
        state_d = (cnt_q == '0) ? S_DONE : S_FREE_USE;
      end
      S_FREE_USE: begin
        cnt_d = cnt_q - 1'b1;
        cur_d = AW'(rd);
        state_d = is_link(rd) ? S_FREE_RD : S_DONE;
      end
      S_KEEP_RD: begin
        state_d = (cnt_q == '0) ? S_CUT_RD : S_KEEP_USE;
      end
      S_KEEP_USE: begin
        if (!is_link(rd)) begin
          state_d = S_DONE;
        end else begin
          cur_d = AW'(rd);
          cnt_d = cnt_q - 1'b1;
          state_d = S_KEEP_RD;
        end
      end
      S_CUT_RD: begin
        state_d = S_CUT_USE;
      end
      S_CUT_USE: begin
        if (is_link(rd)) begin
          cur_d = AW'(rd);
          cnt_d = oldn_q - newn_q;
          state_d = S_FREE_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_status_d = status_q;
          out_start_d = res_q;
          out_found_d = BLK_W'(found_q);
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = cur_q;
    ram_wdata = END_MARK;
    ram_raddr = cur_q;
    div_start = 1'b0;
    div_dividend = tgt_q;
    case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        ram_waddr = ptr_q[AW-1:0];
        ram_wdata = '0;
      end
      S_IDLE: begin
        div_start = in_valid_i;
        div_dividend = cmd_i ? target_i : current_size_i;
      end
      S_DIV_OLD: begin
        div_start = div_done;
      end
      S_CNT_RD: begin
        ram_raddr = ptr_q[AW-1:0];
        ram_we = scan_end && grow_ok && has_tail_q;
      end
      S_FIND_RD: begin
        ram_raddr = ptr_q[AW-1:0];
      end
      S_LINK_WR: begin
        ram_we = has_tail_q;
        ram_wdata = EW'(nb_q);
      end
      S_END_WR: begin
        ram_we = 1'b1;
        ram_waddr = nb_q;
      end
      S_FREE_USE: begin
        ram_we = 1'b1;
        ram_wdata = '0;
      end
      S_CUT_USE: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      ptr_q <= '0;
      out_valid_q <= 1'b0;
      bs_q <= BS_RESET;
      first_q <= FIRST_RESET;
    end else begin
      state_q <= state_d;
      ptr_q <= ptr_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_BLOCK_SIZE: bs_q <= cfg_data_i;
          CFG_FIRST_BLOCK: first_q <= cfg_data_i[BLK_W-1:0];
          default: bs_q <= bs_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_start_q <= out_start_d;
    out_found_q <= out_found_d;
    start_q <= start_d;
    cur_q <= cur_d;
    nb_q <= nb_d;
    tgt_q <= tgt_d;
    cnt_q <= cnt_d;
    oldn_q <= oldn_d;
    newn_q <= newn_d;
    avail_q <= avail_d;
    steps_q <= steps_d;
    has_tail_q <= has_tail_d;
    status_q <= status_d;
    res_q <= res_d;
    found_q <= found_d;
  end

  assign in_stall_o = state_q != S_IDLE;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign status_o = out_status_q;
  assign new_start_block_o = out_start_q;
  assign found_block_o = out_found_q;

endmodule

>>> rtl/fat_chk.sv
// Port checker for the chain resize and locate block, bound to the top level.
// Depends on fat_pkg.
module fat_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          cmd_i,
  input logic [fat_pkg::BLK_W-1:0]     start_block_i,
  input logic [fat_pkg::SIZE_W-1:0]    current_size_i,
  input logic [fat_pkg::SIZE_W-1:0]    target_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [fat_pkg::STAT_W-1:0]    status_o,
  input logic [fat_pkg::BLK_W-1:0]     new_start_block_o,
  input logic [fat_pkg::BLK_W-1:0]     found_block_o,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [fat_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input logic [fat_pkg::BS_W-1:0]      cfg_data_i
);
  import fat_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(new_start_block_o) && $stable(found_block_o))
    else $error("Stalled result beat changed.");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == ST_OK || status_o == ST_FULL || status_o == ST_SHORT)
    else $error("Result beat carries an unknown status.");

  a_fail_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> found_block_o == '0)
    else $error("Failed request reports a found block.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Block took a new beat while still working.");

endmodule

bind fat_chain_resize_and_locate fat_chk u_fat_chk (.*);
